>>> src/ovs_pkg.sv
`default_nettype none

package ovs_pkg;

	localparam int BYTE_W = 8;
	typedef logic [BYTE_W-1:0] byte_t;

	// Longest fixed text is the footer plus its newline
	localparam int TXT_BYTES = 21;
	localparam int TXT_W     = TXT_BYTES * BYTE_W;
	typedef logic [TXT_W-1:0] text_t;
	typedef logic [4:0]       tlen_t;

	// Text styles
	typedef logic [1:0] style_t;
	localparam style_t STY_ROMAN  = 2'd0;
	localparam style_t STY_ITALIC = 2'd1;
	localparam style_t STY_BOLD   = 2'd2;

	// Parser modes
	typedef logic [1:0] mode_t;
	localparam mode_t MODE_TEXT = 2'd0;
	localparam mode_t MODE_ESC  = 2'd1;
	localparam mode_t MODE_CSI  = 2'd2;
	localparam mode_t MODE_BS   = 2'd3;

	// Input bytes with a meaning of their own
	localparam byte_t CH_NL       = 8'h0A;
	localparam byte_t CH_ESC      = 8'h1B;
	localparam byte_t CH_BS       = 8'h08;
	localparam byte_t CH_US       = 8'h5F;
	localparam byte_t CH_LBRACKET = 8'h5B;
	localparam byte_t CSI_FINAL   = 8'h40;
	localparam byte_t CH_LT       = 8'h3C;
	localparam byte_t CH_GT       = 8'h3E;
	localparam byte_t CH_AMP      = 8'h26;
	localparam byte_t CH_AUML_U   = 8'hC4;
	localparam byte_t CH_OUML_U   = 8'hD6;
	localparam byte_t CH_UUML_U   = 8'hDC;
	localparam byte_t CH_AUML_L   = 8'hE4;
	localparam byte_t CH_OUML_L   = 8'hF6;
	localparam byte_t CH_UUML_L   = 8'hFC;
	localparam byte_t CH_SZLIG    = 8'hDF;

	// How the written character is rendered
	typedef logic [3:0] chr_t;
	localparam chr_t CHR_NONE   = 4'd0;
	localparam chr_t CHR_LIT    = 4'd1;
	localparam chr_t CHR_LT     = 4'd2;
	localparam chr_t CHR_GT     = 4'd3;
	localparam chr_t CHR_AMP    = 4'd4;
	localparam chr_t CHR_AUML_U = 4'd5;
	localparam chr_t CHR_OUML_U = 4'd6;
	localparam chr_t CHR_UUML_U = 4'd7;
	localparam chr_t CHR_AUML_L = 4'd8;
	localparam chr_t CHR_OUML_L = 4'd9;
	localparam chr_t CHR_UUML_L = 4'd10;
	localparam chr_t CHR_SZLIG  = 4'd11;

	// Output segments, in emission order
	typedef logic [2:0] seg_t;
	localparam seg_t SEG_HDR   = 3'd0;
	localparam seg_t SEG_CLOSE = 3'd1;
	localparam seg_t SEG_OPEN  = 3'd2;
	localparam seg_t SEG_CHR   = 3'd3;
	localparam seg_t SEG_FTR   = 3'd4;
	localparam seg_t SEG_NONE  = 3'd5;

	// Fixed texts, right aligned
	localparam text_t TXT_HDR       = text_t'("<HTML><BODY><PRE>");
	localparam text_t TXT_FTR       = text_t'("</PRE></BODY></HTML>\n");
	localparam text_t TXT_EM_OPEN   = text_t'("<EM>");
	localparam text_t TXT_EM_CLOSE  = text_t'("</EM>");
	localparam text_t TXT_ST_OPEN   = text_t'("<STRONG>");
	localparam text_t TXT_ST_CLOSE  = text_t'("</STRONG>");
	localparam text_t TXT_LT        = text_t'("&lt;");
	localparam text_t TXT_GT        = text_t'("&gt;");
	localparam text_t TXT_AMP       = text_t'("&amp;");
	localparam text_t TXT_AUML_U    = text_t'("&Auml;");
	localparam text_t TXT_OUML_U    = text_t'("&Ouml;");
	localparam text_t TXT_UUML_U    = text_t'("&Uuml;");
	localparam text_t TXT_AUML_L    = text_t'("&auml;");
	localparam text_t TXT_OUML_L    = text_t'("&ouml;");
	localparam text_t TXT_UUML_L    = text_t'("&uuml;");
	localparam text_t TXT_SZLIG     = text_t'("&szlig;");

	// Everything one item emits
	typedef struct packed {
		logic   hdr;
		style_t close_sel;
		style_t open_sel;
		chr_t   chr_code;
		byte_t  chr_lit;
		logic   ftr;
	} plan_t;

	typedef struct packed {
		text_t txt;
		tlen_t len;
	} segtxt_t;

	// Text and length of one segment of a plan (empty when length is zero)
	function automatic segtxt_t seg_text(input plan_t p, input seg_t s);
		segtxt_t r;
		r.txt = '0;
		r.len = '0;
		case (s)
			SEG_HDR: begin
				if (p.hdr) begin
					r.txt = TXT_HDR;
					r.len = 5'd17;
				end
			end
			SEG_CLOSE: begin
				case (p.close_sel)
					STY_ITALIC: begin r.txt = TXT_EM_CLOSE; r.len = 5'd5; end
					STY_BOLD:   begin r.txt = TXT_ST_CLOSE; r.len = 5'd9; end
					default: ;
				endcase
			end
			SEG_OPEN: begin
				case (p.open_sel)
					STY_ITALIC: begin r.txt = TXT_EM_OPEN; r.len = 5'd4; end
					STY_BOLD:   begin r.txt = TXT_ST_OPEN; r.len = 5'd8; end
					default: ;
				endcase
			end
			SEG_CHR: begin
				case (p.chr_code)
					CHR_LIT:    begin r.txt = text_t'(p.chr_lit); r.len = 5'd1; end
					CHR_LT:     begin r.txt = TXT_LT;     r.len = 5'd4; end
					CHR_GT:     begin r.txt = TXT_GT;     r.len = 5'd4; end
					CHR_AMP:    begin r.txt = TXT_AMP;    r.len = 5'd5; end
					CHR_AUML_U: begin r.txt = TXT_AUML_U; r.len = 5'd6; end
					CHR_OUML_U: begin r.txt = TXT_OUML_U; r.len = 5'd6; end
					CHR_UUML_U: begin r.txt = TXT_UUML_U; r.len = 5'd6; end
					CHR_AUML_L: begin r.txt = TXT_AUML_L; r.len = 5'd6; end
					CHR_OUML_L: begin r.txt = TXT_OUML_L; r.len = 5'd6; end
					CHR_UUML_L: begin r.txt = TXT_UUML_L; r.len = 5'd6; end
					CHR_SZLIG:  begin r.txt = TXT_SZLIG;  r.len = 5'd7; end
					default: ;
				endcase
			end
			SEG_FTR: begin
				if (p.ftr) begin
					r.txt = TXT_FTR;
					r.len = 5'd21;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// First non-empty segment at or after 'from', SEG_NONE if there is none
	function automatic seg_t first_seg(input plan_t p, input seg_t from);
		seg_t    r;
		segtxt_t t;
		r = SEG_NONE;
		for (int k = int'(SEG_FTR); k >= 0; k--) begin
			t = seg_text(p, seg_t'(k));
			if (seg_t'(k) >= from && t.len != '0)
				r = seg_t'(k);
		end
		return r;
	endfunction

	// Rendering of a written character
	function automatic chr_t chr_code_of(input byte_t c);
		chr_t r;
		case (c)
			CH_LT:     r = CHR_LT;
			CH_GT:     r = CHR_GT;
			CH_AMP:    r = CHR_AMP;
			CH_AUML_U: r = CHR_AUML_U;
			CH_OUML_U: r = CHR_OUML_U;
			CH_UUML_U: r = CHR_UUML_U;
			CH_AUML_L: r = CHR_AUML_L;
			CH_OUML_L: r = CHR_OUML_L;
			CH_UUML_L: r = CHR_UUML_L;
			CH_SZLIG:  r = CHR_SZLIG;
			default:   r = CHR_LIT;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> src/ovs_text_if.sv
`default_nettype none

interface ovs_text_if import ovs_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t in_byte;
	logic  end_of_stream;

	modport source (output valid, output in_byte, output end_of_stream, input ready);
	modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

>>> src/ovs_html_if.sv
`default_nettype none

interface ovs_html_if import ovs_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  run_last;

	modport source (output valid, output out_byte, output run_last, input ready);
	modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

`default_nettype wire

>>> src/overstrike_text_to_html.sv
`default_nettype none

// Channel  Dir  Payload                         Handshake
// text     in   in_byte[7:0], end_of_stream     valid/ready
// html     out  out_byte[7:0], run_last         valid/ready
//
// One HTML byte leaves per cycle while html is ready; an item emits 0 to 41
// bytes, read out by the segment walker one byte a cycle unless html stalls.
// An item with no output is taken at once, back to back with the next one.
// The next item is taken in the cycle the last byte of the current one
// moves into the output register. Stalls on html hold that register and
// backpressure text. Reset clears parser state; no clearing pass.

module overstrike_text_to_html import ovs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	ovs_text_if.sink  text,
	ovs_html_if.source html
);

	// Parser state
	byte_t  held_char_q;
	style_t held_style_q;
	style_t open_style_q;
	logic [1:0] nl_run_q;
	mode_t  mode_q;
	logic   hdr_done_q;

	// Segment walker
	plan_t  plan_s1;
	logic   plan_v_s1;
	seg_t   seg_s1;
	tlen_t  off_s1;

	// Output register
	logic   out_v_q;
	byte_t  out_byte_q;
	logic   run_last_q;

	plan_t   plan_in;
	seg_t    first_in;
	logic    do_write;
	logic    accept;
	segtxt_t cur;
	seg_t    nxt;
	tlen_t   pos;
	logic    seg_end;
	logic    is_last;
	logic    can_emit;
	byte_t   cur_byte;

	// Plan of the incoming item
	always_comb begin
		do_write = text.end_of_stream ||
			(mode_q == MODE_TEXT && text.in_byte != CH_ESC && text.in_byte != CH_BS);
		plan_in           = '0;
		plan_in.hdr       = !hdr_done_q;
		plan_in.ftr       = text.end_of_stream;
		plan_in.close_sel = STY_ROMAN;
		plan_in.open_sel  = STY_ROMAN;
		plan_in.chr_code  = CHR_NONE;
		plan_in.chr_lit   = held_char_q;
		if (do_write) begin
			if (held_style_q != open_style_q) begin
				plan_in.close_sel = open_style_q;
				plan_in.open_sel  = held_style_q;
			end
			if (held_char_q == CH_NL && nl_run_q > 2'd1)
				plan_in.chr_code = CHR_NONE;
			else
				plan_in.chr_code = chr_code_of(held_char_q);
		end
		first_in = first_seg(plan_in, SEG_HDR);
	end

	// Current byte of the walker
	always_comb begin
		cur      = seg_text(plan_s1, seg_s1);
		pos      = cur.len - 5'd1 - off_s1;
		cur_byte = cur.txt[{pos, 3'b000} +: BYTE_W];
		seg_end  = (off_s1 == cur.len - 5'd1);
		nxt      = first_seg(plan_s1, seg_t'(seg_s1 + 3'd1));
		is_last  = seg_end && nxt == SEG_NONE;
		can_emit = plan_v_s1 && (!out_v_q || html.ready);
	end

	assign text.ready = !plan_v_s1 || (can_emit && is_last);
	assign accept     = text.valid && text.ready;

	// Parser state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_char_q  <= CH_NL;
			held_style_q <= STY_ROMAN;
			open_style_q <= STY_ROMAN;
			nl_run_q     <= 2'd0;
			mode_q       <= MODE_TEXT;
			hdr_done_q   <= 1'b0;
		end else if (accept) begin
			if (text.end_of_stream) begin
				held_char_q  <= CH_NL;
				held_style_q <= STY_ROMAN;
				open_style_q <= STY_ROMAN;
				nl_run_q     <= 2'd0;
				mode_q       <= MODE_TEXT;
				hdr_done_q   <= 1'b0;
			end else begin
				hdr_done_q <= 1'b1;
				unique case (mode_q)
					MODE_ESC: begin
						mode_q <= (text.in_byte == CH_LBRACKET) ? MODE_CSI : MODE_TEXT;
					end
					MODE_CSI: begin
						if (text.in_byte >= CSI_FINAL)
							mode_q <= MODE_TEXT;
					end
					MODE_BS: begin
						mode_q <= MODE_TEXT;
						if (held_char_q == CH_US) begin
							held_char_q  <= text.in_byte;
							held_style_q <= STY_ITALIC;
						end else if (text.in_byte == held_char_q) begin
							held_style_q <= STY_BOLD;
						end else begin
							held_char_q <= text.in_byte;
						end
					end
					default: begin
						if (text.in_byte == CH_ESC) begin
							mode_q <= MODE_ESC;
						end else if (text.in_byte == CH_BS) begin
							mode_q <= MODE_BS;
						end else begin
							open_style_q <= held_style_q;
							if (held_char_q == CH_NL) begin
								if (nl_run_q <= 2'd1)
									nl_run_q <= nl_run_q + 2'd1;
							end else begin
								nl_run_q <= 2'd0;
							end
							held_char_q  <= text.in_byte;
							held_style_q <= STY_ROMAN;
						end
					end
				endcase
			end
		end
	end

	// Walker control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plan_v_s1 <= 1'b0;
			seg_s1    <= SEG_HDR;
			off_s1    <= '0;
		end else if (accept) begin
			plan_v_s1 <= (first_in != SEG_NONE);
			seg_s1    <= first_in;
			off_s1    <= '0;
		end else if (can_emit) begin
			if (is_last) begin
				plan_v_s1 <= 1'b0;
			end else if (seg_end) begin
				seg_s1 <= nxt;
				off_s1 <= '0;
			end else begin
				off_s1 <= off_s1 + 5'd1;
			end
		end
	end

	// Walker plan payload
	always_ff @(posedge clk) begin
		if (accept)
			plan_s1 <= plan_in;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (can_emit) begin
			out_v_q <= 1'b1;
		end else if (html.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (can_emit) begin
			out_byte_q <= cur_byte;
			run_last_q <= is_last;
		end
	end

	assign html.valid    = out_v_q;
	assign html.out_byte = out_byte_q;
	assign html.run_last = run_last_q;

endmodule

`default_nettype wire

>>> test/tb.sv
`default_nettype none

module tb import ovs_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int N_DIR       = 30;
	localparam int N_RANDOM    = 280;
	localparam int CALM_LO     = 150;
	localparam int CALM_HI     = 230;
	localparam int TAIL_CYCLES = 80;

	typedef struct {
		byte_t b;
		logic  eos;
		int    row;
		bit    drain;
	} text_item_t;

	typedef struct packed {
		byte_t b;
		logic  run_end;
	} html_item_t;

	typedef struct packed {
		logic  eos;
		byte_t b;
	} dir_row_t;

	logic clk;
	logic arst_n;

	ovs_text_if text_ch ();
	ovs_html_if html_ch ();

	overstrike_text_to_html i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.html   (html_ch)
	);

	// Directed stimulus; an empty text means the predictor supplies the bytes
	dir_row_t dir_rows [N_DIR] = '{
		'{1'b1, 8'hFF},        // end right after reset
		'{1'b0, 8'h41},        // 'A'
		'{1'b0, CH_LT},
		'{1'b0, CH_GT},
		'{1'b0, CH_AMP},
		'{1'b0, CH_AUML_U},
		'{1'b0, CH_SZLIG},
		'{1'b0, 8'h00},
		'{1'b0, 8'hFF},
		'{1'b0, CH_US},        // underscore, backspace, x: italic x
		'{1'b0, CH_BS},
		'{1'b0, 8'h78},
		'{1'b0, CH_NL},        // newline run
		'{1'b0, CH_NL},
		'{1'b0, CH_NL},
		'{1'b0, CH_BS},        // bold newline: tags kept, newline dropped
		'{1'b0, CH_NL},
		'{1'b0, 8'h6B},
		'{1'b0, CH_BS},        // k backspace k: bold
		'{1'b0, 8'h6B},
		'{1'b0, CH_BS},        // backspace with a different byte
		'{1'b0, 8'h6D},
		'{1'b0, CH_ESC},       // ESC plus one byte
		'{1'b0, 8'h63},
		'{1'b0, CH_ESC},       // control sequence
		'{1'b0, CH_LBRACKET},
		'{1'b0, 8'h31},
		'{1'b0, CSI_FINAL},
		'{1'b0, CH_ESC},       // end inside an escape, bold still open
		'{1'b1, 8'h00}
	};

	string dir_html [N_DIR] = '{
		"<HTML><BODY><PRE>\n</PRE></BODY></HTML>\n",
		"<HTML><BODY><PRE>\n",
		"A",
		"&lt;",
		"&gt;",
		"&amp;",
		"&Auml;",
		"&szlig;",
		"", "", "", "", "", "", "", "", "", "", "", "", "", "", "", "", "", "", "", "",
		"", ""
	};

	byte_t ent_chars [10] = '{CH_LT, CH_GT, CH_AMP, CH_AUML_U, CH_OUML_U,
		CH_UUML_U, CH_AUML_L, CH_OUML_L, CH_UUML_L, CH_SZLIG};

	text_item_t text_q[$];
	string      known_html[$];
	html_item_t html_exp[$];
	html_item_t step_q[$];

	int n_acc;
	int n_errors;
	int cycles;
	int n_rand;
	bit drain_next;

	// Converter state as the predictor sees it
	byte_t  h_char;
	style_t h_style;
	style_t o_style;
	logic [1:0] nl_run;
	mode_t  p_mode;
	logic   hdr_done;

	task automatic reset_conv();
		h_char   = CH_NL;
		h_style  = STY_ROMAN;
		o_style  = STY_ROMAN;
		nl_run   = 2'd0;
		p_mode   = MODE_TEXT;
		hdr_done = 1'b0;
	endtask

	task automatic emit_byte(byte_t b);
		html_item_t e;
		e.b       = b;
		e.run_end = 1'b0;
		step_q.push_back(e);
	endtask

	task automatic emit_str(string s);
		for (int i = 0; i < s.len(); i++)
			emit_byte(byte_t'(s[i]));
	endtask

	// Write one held byte with its style, switching tags as needed
	task automatic write_held(byte_t c, style_t sty);
		if (sty != o_style) begin
			case (o_style)
				STY_ITALIC: emit_str("</EM>");
				STY_BOLD:   emit_str("</STRONG>");
				default: ;
			endcase
			o_style = sty;
			case (sty)
				STY_ITALIC: emit_str("<EM>");
				STY_BOLD:   emit_str("<STRONG>");
				default: ;
			endcase
		end
		if (c == CH_NL) begin
			if (nl_run > 2'd1)
				return;
			nl_run++;
		end else begin
			nl_run = 2'd0;
		end
		case (c)
			CH_LT:     emit_str("&lt;");
			CH_GT:     emit_str("&gt;");
			CH_AMP:    emit_str("&amp;");
			CH_AUML_U: emit_str("&Auml;");
			CH_OUML_U: emit_str("&Ouml;");
			CH_UUML_U: emit_str("&Uuml;");
			CH_AUML_L: emit_str("&auml;");
			CH_OUML_L: emit_str("&ouml;");
			CH_UUML_L: emit_str("&uuml;");
			CH_SZLIG:  emit_str("&szlig;");
			default:   emit_byte(c);
		endcase
	endtask

	// HTML bytes caused by one text item
	task automatic render_item(byte_t c, logic eos);
		step_q.delete();
		if (!hdr_done) begin
			emit_str("<HTML><BODY><PRE>");
			hdr_done = 1'b1;
		end
		if (eos) begin
			write_held(h_char, h_style);
			emit_str("</PRE></BODY></HTML>");
			emit_byte(CH_NL);
			reset_conv();
		end else begin
			case (p_mode)
				MODE_ESC: begin
					p_mode = (c == CH_LBRACKET) ? MODE_CSI : MODE_TEXT;
				end
				MODE_CSI: begin
					if (c >= CSI_FINAL)
						p_mode = MODE_TEXT;
				end
				MODE_BS: begin
					p_mode = MODE_TEXT;
					if (h_char == CH_US) begin
						h_char  = c;
						h_style = STY_ITALIC;
					end else if (c == h_char) begin
						h_style = STY_BOLD;
					end else begin
						h_char = c;
					end
				end
				default: begin
					if (c == CH_ESC) begin
						p_mode = MODE_ESC;
					end else if (c == CH_BS) begin
						p_mode = MODE_BS;
					end else begin
						write_held(h_char, h_style);
						h_char  = c;
						h_style = STY_ROMAN;
					end
				end
			endcase
		end
	endtask

	// Accepted text item: predict, take typed text where given, queue it up
	task automatic take_text(text_item_t it);
		render_item(it.b, it.eos);
		if (it.row >= 0) begin
			step_q.delete();
			emit_str(known_html[it.row]);
		end
		if (step_q.size() != 0)
			step_q[step_q.size() - 1].run_end = 1'b1;
		foreach (step_q[i])
			html_exp.push_back(step_q[i]);
	endtask

	task automatic add_item(byte_t b, logic eos, string txt);
		text_item_t it;
		it.b     = b;
		it.eos   = eos;
		it.row   = -1;
		it.drain = drain_next;
		drain_next = 1'b0;
		if (txt.len() != 0) begin
			it.row = known_html.size();
			known_html.push_back(txt);
		end
		text_q.push_back(it);
	endtask

	task automatic add_rand(byte_t b, logic eos);
		add_item(b, eos, "");
		n_rand++;
	endtask

	function automatic byte_t any_byte();
		return byte_t'($urandom_range(0, 255));
	endfunction

	function automatic byte_t print_byte();
		return byte_t'($urandom_range(32, 126));
	endfunction

	// Mostly well-formed overstrike and escape sequences, some noise
	task automatic add_random_piece();
		int    kind;
		int    n;
		byte_t c;
		kind = $urandom_range(0, 99);
		if (kind < 28) begin
			add_rand(print_byte(), 1'b0);
		end else if (kind < 38) begin
			add_rand(ent_chars[$urandom_range(0, 9)], 1'b0);
		end else if (kind < 48) begin
			c = $urandom_range(0, 1) ? any_byte() : ent_chars[$urandom_range(0, 9)];
			add_rand(CH_US, 1'b0);
			add_rand(CH_BS, 1'b0);
			add_rand(c, 1'b0);
		end else if (kind < 58) begin
			c = $urandom_range(0, 1) ? print_byte() : any_byte();
			add_rand(c, 1'b0);
			add_rand(CH_BS, 1'b0);
			add_rand(c, 1'b0);
		end else if (kind < 62) begin
			add_rand(print_byte(), 1'b0);
			add_rand(CH_BS, 1'b0);
			add_rand(print_byte(), 1'b0);
		end else if (kind < 70) begin
			n = $urandom_range(1, 4);
			repeat (n) add_rand(CH_NL, 1'b0);
		end else if (kind < 75) begin
			add_rand(CH_ESC, 1'b0);
			add_rand(any_byte(), 1'b0);
		end else if (kind < 81) begin
			add_rand(CH_ESC, 1'b0);
			add_rand(CH_LBRACKET, 1'b0);
			n = $urandom_range(0, 3);
			repeat (n) add_item(byte_t'($urandom_range(0, 63)), 1'b0, "");
			add_rand(byte_t'($urandom_range(64, 255)), 1'b0);
		end else if (kind < 84) begin
			add_rand(any_byte(), 1'b1);
		end else if (kind < 96) begin
			add_rand(any_byte(), 1'b0);
		end else begin
			// broken sequence cut off by the end of the stream
			add_rand($urandom_range(0, 1) ? CH_ESC : CH_BS, 1'b0);
			add_rand(any_byte(), 1'b1);
		end
	endtask

	function automatic bit stall_roll();
		if (n_acc >= CALM_LO && n_acc < CALM_HI)
			return 1'b0;
		return $urandom_range(0, 99) < 38;
	endfunction

	// Clock and reset
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still expected", $time, html_exp.size());
			$display("status: fail");
			$finish;
		end
	end

	// HTML side: random ready, check each item against the oldest expectation
	initial begin
		html_item_t e;
		html_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (html_ch.valid && html_ch.ready) begin
				if (html_exp.size() == 0) begin
					$display("%0t: unexpected item, expected none, actual %02h last %b",
						$time, html_ch.out_byte, html_ch.run_last);
					n_errors++;
				end else begin
					e = html_exp.pop_front();
					if (html_ch.out_byte !== e.b) begin
						$display("%0t: out_byte expected %02h, actual %02h",
							$time, e.b, html_ch.out_byte);
						n_errors++;
					end
					if (html_ch.run_last !== e.run_end) begin
						$display("%0t: run_last expected %b, actual %b",
							$time, e.run_end, html_ch.run_last);
						n_errors++;
					end
				end
			end
			html_ch.ready <= !stall_roll();
		end
	end

	// Text side: build stimulus, drive it, predict on acceptance
	initial begin
		text_item_t cur;
		bit         busy;
		text_ch.valid         <= 1'b0;
		text_ch.in_byte       <= '0;
		text_ch.end_of_stream <= 1'b0;
		n_acc      = 0;
		n_errors   = 0;
		cycles     = 0;
		n_rand     = 0;
		busy       = 1'b0;
		drain_next = 1'b0;
		reset_conv();

		for (int i = 0; i < N_DIR; i++)
			add_item(dir_rows[i].b, dir_rows[i].eos, dir_html[i]);
		drain_next = 1'b1;
		while (n_rand < N_RANDOM) begin
			if (n_rand >= N_RANDOM / 2 && n_rand < N_RANDOM / 2 + 4)
				drain_next = 1'b1;
			add_random_piece();
		end
		add_rand(any_byte(), 1'b1);

		wait (arst_n === 1'b1);
		while (text_q.size() != 0 || busy) begin
			@(posedge clk);
			if (busy && text_ch.valid && text_ch.ready) begin
				take_text(cur);
				n_acc++;
				busy = 1'b0;
			end
			if (!busy && text_q.size() != 0 && !stall_roll()
					&& !(text_q[0].drain && html_exp.size() != 0)) begin
				cur = text_q.pop_front();
				text_ch.valid         <= 1'b1;
				text_ch.in_byte       <= cur.b;
				text_ch.end_of_stream <= cur.eos;
				busy = 1'b1;
			end else if (!busy) begin
				text_ch.valid <= 1'b0;
			end
		end

		// drain, then give the block time to show any stray output
		while (html_exp.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (html_exp.size() != 0) begin
			$display("%0t: %0d expected items never arrived", $time, html_exp.size());
			n_errors++;
		end
		if (n_errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
src/ovs_pkg.sv
src/ovs_text_if.sv
src/ovs_html_if.sv
src/overstrike_text_to_html.sv
test/tb.sv
